// ===== sv/atp_pkg.sv =====
package atp_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned LOOP_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned TOTMS_W    = 40;
  localparam int unsigned PROD_W     = LOOP_W + 1 + COUNT_W;
  localparam int unsigned TOT_W      = PROD_W - 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_BEGIN_DELAY  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_LENGTH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_MODE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_COUNT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_TOTAL = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_REVERSE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_PLAY = 3'd6;

  localparam logic [1:0] RPT_COUNT    = 2'd0;
  localparam logic [1:0] RPT_DURATION = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd256;

  localparam logic CMD_BEGIN = 1'b0;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_ACTIVE  = 2'd1,
    PH_FILLING = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_DECIDE,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== sv/animation_timeline_progress_core.sv =====
// Animation timeline clock. Each request on the slave stream is a begin command
// (tuser 0) or a timer tick (tuser 1) carrying the current millisecond time; each
// one yields exactly one result with Q1.PROGRESS_FRAC_BITS progress, the run phase
// and the processed / completed / phase-changed flags. Progress is a fixed value
// when stopped, before start, with zero loop length or past the end; otherwise
// elapsed time is divided by the loop length, which is done by one radix-2
// restoring divider producing one quotient bit per cycle. The slave side is ready
// only while no request is in progress; a finished result waits in the output
// register, so the next request may be taken before it is read. Configuration
// registers are written through cfg_we_i / cfg_addr_i / cfg_data_i and must only
// change while the block is idle.
module animation_timeline_progress_core #(
  parameter int unsigned TIME_BITS          = 48,
  parameter int unsigned PROGRESS_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [atp_pkg::CFG_ADDR_W-1:0]          cfg_addr_i,
  input  logic [atp_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // now_ms
  input  logic [((TIME_BITS+7)/8)*8-1:0]          s_axis_tdata,
  // mode
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // progress, phase, processed, completed, phase_changed
  output logic [((PROGRESS_FRAC_BITS+6+7)/8)*8-1:0] m_axis_tdata
);

  import atp_pkg::*;

  localparam int unsigned F      = PROGRESS_FRAC_BITS;
  localparam int unsigned PW     = F + 1;
  localparam int unsigned DVD_W  = TIME_BITS + F;
  localparam int unsigned OUT_W  = ((PW + 5 + 7) / 8) * 8;
  localparam int unsigned CMP_W  = (TIME_BITS > TOT_W) ? TIME_BITS : TOT_W;
  localparam logic [PW-1:0] PONE = PW'(1) << F;

  // configuration
  logic [DELAY_W-1:0] delay_q;
  logic [LOOP_W-1:0]  loop_q;
  logic [1:0]         rmode_q;
  logic [COUNT_W-1:0] count_q;
  logic [TOTMS_W-1:0] totms_q;
  logic               arev_q;
  logic               rplay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      loop_q  <= '0;
      rmode_q <= RPT_COUNT;
      count_q <= COUNT_RESET;
      totms_q <= '0;
      arev_q  <= 1'b0;
      rplay_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BEGIN_DELAY:  delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_LOOP_LENGTH:  loop_q  <= cfg_data_i[LOOP_W-1:0];
        CFG_REPEAT_MODE:  rmode_q <= cfg_data_i[1:0];
        CFG_REPEAT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_REPEAT_TOTAL: totms_q <= cfg_data_i[TOTMS_W-1:0];
        CFG_AUTO_REVERSE: arev_q  <= cfg_data_i[0];
        CFG_REVERSE_PLAY: rplay_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [TIME_BITS-1:0] start_q;
  logic                 m_valid_q;

  logic                 mode_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] elapsed_q;
  logic                 ge_q;
  logic [TOT_W-1:0]     total_q;
  logic [PW-1:0]        prog_q, prog_d;
  logic                 proc_q, proc_d;
  logic                 comp_q, comp_d;
  logic                 chg_q, chg_d;
  logic [OUT_W-1:0]     out_q;

  logic                 accept;
  logic                 load_start;
  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        quot;
  logic [PW-1:0]        folded;
  logic                 out_load;
  logic                 endless;
  logic                 tot_nz;
  logic [TIME_BITS:0]   diff;
  logic [LOOP_W:0]      pass;
  logic [PROD_W-1:0]    prod;
  logic [TOT_W-1:0]     total_d;
  logic [CMP_W-1:0]     el_w;
  logic [CMP_W-1:0]     tot_w;
  logic [PW-1:0]        startv;
  logic [PW-1:0]        endv;

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign endless = rmode_q[1];
  assign tot_nz  = (total_q != '0);
  assign diff    = {1'b0, now_q} - {1'b0, start_q};
  assign pass    = arev_q ? {loop_q, 1'b0} : {1'b0, loop_q};
  assign prod    = pass * count_q;
  assign el_w    = CMP_W'(elapsed_q);
  assign tot_w   = CMP_W'(total_q);
  assign startv  = rplay_q ? PONE : '0;
  assign endv    = (arev_q == rplay_q) ? PONE : '0;

  always_comb begin
    unique case (rmode_q)
      RPT_COUNT:    total_d = prod[PROD_W-1:8];
      RPT_DURATION: total_d = TOT_W'(totms_q);
      default:      total_d = '0;
    endcase
  end

  always_comb begin
    folded = {1'b0, quot[F-1:0]};
    if (arev_q && quot[F]) begin
      folded = PONE - folded;
    end
    if (rplay_q) begin
      folded = PONE - folded;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    prog_d     = prog_q;
    proc_d     = proc_q;
    comp_d     = comp_q;
    chg_d      = chg_q;
    load_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        load_start = (mode_q == CMD_BEGIN);
        state_d    = S_CALC;
      end
      S_CALC: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        proc_d = 1'b0;
        comp_d = 1'b0;
        chg_d  = 1'b0;
        if (mode_q == CMD_BEGIN) begin
          phase_d = PH_ACTIVE;
          chg_d   = 1'b1;
        end else if (phase_q == PH_ACTIVE && ge_q) begin
          proc_d = endless | tot_nz;
          if (!endless && el_w >= tot_w) begin
            phase_d = PH_FILLING;
            comp_d  = 1'b1;
            chg_d   = 1'b1;
          end
        end
        state_d = S_OUT;
        if (phase_d != PH_ACTIVE || (!endless && !tot_nz) || !ge_q || loop_q == '0) begin
          prog_d = startv;
        end else if (!endless && el_w > tot_w) begin
          prog_d = endv;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prog_d  = folded;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_STOPPED;
      start_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (load_start) begin
        start_q <= now_q + TIME_BITS'(delay_q);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser;
      now_q  <= s_axis_tdata[TIME_BITS-1:0];
    end
    if (state_q == S_CALC) begin
      elapsed_q <= diff[TIME_BITS-1:0];
      ge_q      <= ~diff[TIME_BITS];
      total_q   <= total_d;
    end
    prog_q <= prog_d;
    proc_q <= proc_d;
    comp_q <= comp_d;
    chg_q  <= chg_d;
    if (out_load) begin
      out_q <= OUT_W'({chg_q, comp_q, proc_q, phase_q, prog_q});
    end
  end

  atp_div #(
    .DVD_W (DVD_W),
    .DSR_W (LOOP_W),
    .QW    (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({elapsed_q, F'(0)}),
    .divisor_i  (loop_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_comp_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && comp_q |-> phase_q == PH_FILLING && chg_q)
    else $error("completion without entering filling");

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> prog_q <= PONE)
    else $error("progress beyond one");

  a_begin_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE && mode_q == CMD_BEGIN |=> phase_q == PH_ACTIVE && chg_q)
    else $error("begin did not enter active phase");
`endif

endmodule

// ===== sv/atp_div.sv =====
module atp_div #(
  parameter int unsigned DVD_W = 64,
  parameter int unsigned DSR_W = 32,
  parameter int unsigned QW    = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QW-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DSR_W-1:0] rem_q;
  logic [QW-1:0]    quo_q;

  logic [DSR_W+1:0] diff;
  logic             fits;

  // restoring radix-2 step
  assign diff = {1'b0, rem_q, dvd_q[DVD_W-1]} - {2'b00, divisor_i};
  assign fits = ~diff[DSR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= fits ? diff[DSR_W-1:0] : {rem_q[DSR_W-2:0], dvd_q[DVD_W-1]};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
